>>> hw/rtl/double_precision_float_multiplier_unit_macros.svh
// assertion helpers for the float multiplier unit
`ifndef DOUBLE_PRECISION_FLOAT_MULTIPLIER_UNIT_MACROS_SVH
`define DOUBLE_PRECISION_FLOAT_MULTIPLIER_UNIT_MACROS_SVH

// clocked check, quiet during reset
`define FPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication check, quiet during reset
`define FPM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fpm_pkg.sv
package fpm_pkg;
    localparam int WORD_W    = 64;
    localparam int FRAC_BITS = 52;
    localparam int EXP_BITS  = 11;
    localparam int SIG_W     = FRAC_BITS + 1;
    localparam int LO_W      = 27;
    localparam int HI_W      = SIG_W - LO_W;
    localparam int PROD_W    = 2 * SIG_W;
    localparam int EXP_W     = 13;
    localparam logic signed [EXP_W-1:0] EXP_BIAS = 13'sd1023;

    // partial products and exponent/sign of one request
    typedef struct packed {
        logic                       sign;
        logic signed [EXP_W-1:0]    exp;
        logic [2*LO_W-1:0]          ll;
        logic [LO_W+HI_W-1:0]       lh;
        logic [LO_W+HI_W-1:0]       hl;
        logic [2*HI_W-1:0]          hh;
    } pp_t;
endpackage

>>> hw/rtl/double_precision_float_multiplier_unit.sv
// binary64 multiplier, truncated fraction, no special-value handling
//
// input channel: operand_a, operand_b with in_valid / in_ready
// output channel: product, error with out_valid / out_ready
// a request is taken when valid and ready are high at a clock edge
//
// stages: three register stages; operand register, partial product register
//   (four 27x27-class multipliers), then sum, normalize, result register;
//   out_valid rises when a request is loaded into the result register
// throughput: one request per cycle while out_ready is high
//
// the pipeline advances as one: when the result register holds a request
// and out_ready is low, every stage holds and in_ready drops; a taken
// result frees the pipeline in the same cycle
//
// reset clears all stage valid bits; data registers are not reset
// error is set when the normalized exponent is exactly zero, product is
// then zero; otherwise the exponent field wraps to its low 11 bits
module double_precision_float_multiplier_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [fpm_pkg::WORD_W-1:0]  operand_a,
    input  logic [fpm_pkg::WORD_W-1:0]  operand_b,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [fpm_pkg::WORD_W-1:0]  product,
    output logic                        error
);
    import fpm_pkg::*;

    // stage valid bits
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;
    logic               adv;

    // operand register
    logic [WORD_W-1:0]  a_reg;
    logic [WORD_W-1:0]  b_reg;

    // result register
    logic [WORD_W-1:0]  product_reg;
    logic [WORD_W-1:0]  product_next;
    logic               error_reg;
    logic               error_next;

    pp_t                pp;

    // whole pipeline moves unless the result is stuck
    assign adv      = !v3_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg       <= operand_a;
            b_reg       <= operand_b;
            product_reg <= product_next;
            error_reg   <= error_next;
        end
    end

    // partial products, registered inside
    fpm_pp u_pp (
        .clk       (clk),
        .en        (adv),
        .operand_a (a_reg),
        .operand_b (b_reg),
        .pp        (pp)
    );

    // final sum and normalization
    fpm_norm u_norm (
        .pp      (pp),
        .product (product_next),
        .error   (error_next)
    );

    assign out_valid = v3_reg;
    assign product   = product_reg;
    assign error     = error_reg;

`include "double_precision_float_multiplier_unit_macros.svh"

    `FPM_ASSERT(a_err_zero, !(out_valid && error) || (product == '0), "error with nonzero product")
    `FPM_ASSERT(a_ready, in_ready == (!out_valid || out_ready), "in_ready does not follow stall")
    `FPM_ASSERT_IMPL(a_move, v1_reg && adv, v2_reg, "request lost between stages")
    `FPM_ASSERT_IMPL(a_hold, out_valid && !out_ready, out_valid && $stable(product), "stalled result changed")
endmodule

>>> hw/rtl/fpm_pp.sv
module fpm_pp (
    input  logic                        clk,
    input  logic                        en,
    input  logic [fpm_pkg::WORD_W-1:0]  operand_a,
    input  logic [fpm_pkg::WORD_W-1:0]  operand_b,
    output fpm_pkg::pp_t                pp
);
    import fpm_pkg::*;

    logic [SIG_W-1:0] ma;
    logic [SIG_W-1:0] mb;
    pp_t              pp_reg;
    pp_t              pp_next;

    assign ma = {1'b1, operand_a[FRAC_BITS-1:0]};
    assign mb = {1'b1, operand_b[FRAC_BITS-1:0]};

    always_comb
    begin
        pp_next.sign = operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
        // biased exponent sum, before normalization
        pp_next.exp  = $signed({2'b00, operand_a[WORD_W-2:FRAC_BITS]})
                     + $signed({2'b00, operand_b[WORD_W-2:FRAC_BITS]}) - EXP_BIAS;
        pp_next.ll   = ma[LO_W-1:0] * mb[LO_W-1:0];
        pp_next.lh   = ma[LO_W-1:0] * mb[SIG_W-1:LO_W];
        pp_next.hl   = ma[SIG_W-1:LO_W] * mb[LO_W-1:0];
        pp_next.hh   = ma[SIG_W-1:LO_W] * mb[SIG_W-1:LO_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg <= pp_next;
        end
    end

    assign pp = pp_reg;
endmodule

>>> hw/rtl/fpm_norm.sv
module fpm_norm (
    input  fpm_pkg::pp_t                pp,
    output logic [fpm_pkg::WORD_W-1:0]  product,
    output logic                        error
);
    import fpm_pkg::*;

    logic [PROD_W-1:0]          sum;
    logic [FRAC_BITS-1:0]       frac;
    logic signed [EXP_W-1:0]    exp_adj;

    always_comb
    begin
        sum = PROD_W'(pp.ll)
            + (PROD_W'(pp.lh) << LO_W)
            + (PROD_W'(pp.hl) << LO_W)
            + (PROD_W'(pp.hh) << (2 * LO_W));
        // leading one at the top bit: one right shift
        if (sum[PROD_W-1])
        begin
            frac    = sum[PROD_W-2 -: FRAC_BITS];
            exp_adj = pp.exp + EXP_W'(1);
        end
        else
        begin
            frac    = sum[PROD_W-3 -: FRAC_BITS];
            exp_adj = pp.exp;
        end
        error = (exp_adj == '0);
        if (error)
        begin
            product = '0;
        end
        else
        begin
            product = {pp.sign, exp_adj[EXP_BITS-1:0], frac};
        end
    end
endmodule
